### hw/rtl/dcc_pkg.sv
// Shared types, codes and helpers of the DCC correlation filter.
package dcc_pkg;

  localparam int ASSETS_DEF    = 4;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [1:0] {
    KIND_TARGET  = 2'd0,
    KIND_RESID   = 2'd1,
    KIND_SCALE   = 2'd2,
    KIND_ADVANCE = 2'd3
  } kind_t;

  localparam logic [1:0] CFG_A_WEIGHT = 2'd0;
  localparam logic [1:0] CFG_B_WEIGHT = 2'd1;
  localparam logic [1:0] CFG_WARMUP   = 2'd2;

  typedef struct packed {
    kind_t              kind;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] value;
  } in_req_t;

  typedef struct packed {
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [31:0] correlation;
    logic signed [31:0] covariance;
    logic               last;
  } out_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_W_RD, ST_W_EMIT,
    ST_U_RD, ST_U_SQ, ST_U_SQW, ST_U_MUL, ST_U_WR,
    ST_P_RD, ST_P_M1, ST_P_M2, ST_P_M3, ST_P_M4,
    ST_R_RD, ST_R_SQ, ST_R_SQW, ST_R_DV, ST_R_DVW,
    ST_C_RD, ST_C_M1, ST_C_M2, ST_C_M3,
    ST_T_RD, ST_T_MUL, ST_T_ACC,
    ST_H_RD, ST_H_MUL, ST_H_ACC, ST_H_CRD, ST_H_EMIT,
    ST_FIN
  } seq_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sh000000007FFFFFFF) r = 32'sh7FFFFFFF;
    else if (x < -64'sh0000000080000000) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

### hw/rtl/dcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dcc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/dcc_sqrt.sv
// Iterative floor square root, one result bit per cycle.
module dcc_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] x,
  output logic        busy,
  output logic        done,
  output logic [31:0] root
);

  logic        busy_r, done_r;
  logic [4:0]  cnt_r;
  logic [63:0] x_r;
  logic [33:0] rem_r;
  logic [31:0] root_r;
  logic [35:0] rem_t, trial;
  logic        ge;

  assign rem_t = {rem_r, x_r[63:62]};
  assign trial = {2'b00, root_r, 2'b01};
  assign ge    = rem_t >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      x_r    <= x;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r    <= {x_r[61:0], 2'b00};
      rem_r  <= ge ? 34'(rem_t - trial) : 34'(rem_t);
      root_r <= {root_r[30:0], ge};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = root_r;

endmodule

### hw/rtl/dcc_div.sv
// Iterative restoring divider for 2^(2*FRAC_BITS) / divisor, saturated to 31 bits.
module dcc_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [31:0] quot_sat
);

  localparam logic [63:0] DIVIDEND = 64'(1) << (2 * FRAC_BITS);

  logic        busy_r, done_r;
  logic [5:0]  cnt_r;
  logic [63:0] dvd_r, quot_r;
  logic [31:0] dsr_r, rem_r;
  logic [32:0] rem_t;
  logic        ge;

  assign rem_t = {rem_r, dvd_r[63]};
  assign ge    = rem_t >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      dvd_r  <= DIVIDEND;
      dsr_r  <= divisor;
      rem_r  <= '0;
      quot_r <= '0;
    end else if (busy_r) begin
      dvd_r  <= {dvd_r[62:0], 1'b0};
      rem_r  <= ge ? 32'(rem_t - {1'b0, dsr_r}) : rem_t[31:0];
      quot_r <= {quot_r[62:0], ge};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quot_sat = (|quot_r[63:31]) ? 32'h7FFFFFFF : quot_r[31:0];

endmodule

### hw/rtl/dcc_correlation_filter_core.sv
// Top level of the DCC correlation filter: sequencer, shared multiplier and matrix stores.
//
// Channel   Direction  Handshake             Payload
// in_       input      in_valid/in_ready     in_req_t (kind, row, col, value)
// out_      output     out_valid/out_ready   out_rsp_t (row, col, R, H, last)
// cfg_      input      cfg_we                cfg_index, cfg_wdata
//
// A warm-up advance reads and then emits each element in turn. A recursion advance is
// paced by the bit-serial square root and divider and the single multiplier.
// Reset is synchronous; the recursion matrix reads as identity until written.
// A stalled result channel holds the sequencer at its emit step.
module dcc_correlation_filter_core
  import dcc_pkg::*;
#(
  parameter int ASSETS    = ASSETS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_req_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_rsp_t    out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int NN = ASSETS * ASSETS;
  localparam int IW = $clog2(ASSETS);
  localparam int AW = $clog2(NN);
  localparam logic [IW-1:0] ILAST = IW'(ASSETS - 1);
  localparam logic signed [31:0] ONE = 32'(64'(1) << FRAC_BITS);

  function automatic logic [AW-1:0] idx(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(AW'(r) * AW'(ASSETS) + AW'(c));
  endfunction

  seq_state_t state_r, state_nxt;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic signed [63:0] acc_r, acc_nxt, prod_r;
  logic signed [31:0] mul_a, mul_b;
  logic signed [31:0] cov_r, cov_nxt;
  logic [15:0] a_r, b_r;
  logic [7:0]  warm_r, step_r;
  logic signed [31:0] cur_r [ASSETS];
  logic signed [31:0] prev_r [ASSETS];
  logic signed [31:0] u_r [ASSETS];
  logic signed [31:0] rs_r [ASSETS];
  logic [NN-1:0] qv_r;
  logic q_rv_r, q_rdiag_r;
  logic out_valid_r;
  out_rsp_t out_data_r, out_nxt;

  logic in_acc, in_range, warm, out_free, emit;
  logic i_last, j_last, k_last, ij_last;
  logic [IW-1:0] i_inc, j_inc;
  logic u_we, rs_we;
  logic signed [31:0] rs_wdata;
  logic signed [63:0] prod_sh, prod_w, acc_n;
  logic signed [31:0] a_s, b_s, c_s;
  logic signed [17:0] c18;

  logic [AW-1:0] s_raddr, d_raddr, q_raddr, c_raddr, t_raddr, ld_addr;
  logic [31:0] s_rdata, d_rdata, q_rdata, c_rdata, t_rdata;
  logic s_we, d_we, q_we, c_we, t_we;
  logic signed [31:0] q_wdata, c_wdata, t_wdata, q_rd;
  logic [IW-1:0] q_rj;

  logic sq_start, sq_busy, sq_done, dv_start, dv_busy, dv_done;
  logic [63:0] sq_x;
  logic [31:0] sq_root, dv_quot;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign in_range = ({1'b0, in_data.row} < 4'(ASSETS)) && ({1'b0, in_data.col} < 4'(ASSETS));
  assign warm     = step_r < warm_r;
  assign out_free = !out_valid_r || out_ready;
  assign i_last   = (i_r == ILAST);
  assign j_last   = (j_r == ILAST);
  assign k_last   = (k_r == ILAST);
  assign ij_last  = i_last && j_last;
  assign j_inc    = j_last ? '0 : j_r + 1'b1;
  assign i_inc    = j_last ? (i_last ? '0 : i_r + 1'b1) : i_r;
  assign ld_addr  = idx(in_data.row[IW-1:0], in_data.col[IW-1:0]);

  assign prod_sh = prod_r >>> FRAC_BITS;
  assign prod_w  = prod_r >>> 16;
  assign a_s     = $signed({16'b0, a_r});
  assign b_s     = $signed({16'b0, b_r});
  assign c18     = 18'sd65536 - $signed({2'b0, a_r}) - $signed({2'b0, b_r});
  assign c_s     = 32'(c18);

  assign q_rd = q_rv_r ? $signed(q_rdata) : (q_rdiag_r ? ONE : 32'sd0);
  assign sq_x = (q_rd > 32'sd0) ? ({32'b0, q_rd} << FRAC_BITS) : 64'd0;

  // Read address selection by phase.
  always_comb begin
    s_raddr = idx(i_r, j_r);
    q_rj    = j_r;
    d_raddr = idx(i_r, k_r);
    c_raddr = idx(i_r, j_r);
    t_raddr = idx(i_r, k_r);
    unique case (state_r)
      ST_U_RD, ST_U_SQ, ST_R_RD, ST_R_SQ: q_rj = i_r;
      ST_T_RD, ST_T_MUL, ST_T_ACC: c_raddr = idx(k_r, j_r);
      ST_H_RD, ST_H_MUL, ST_H_ACC: d_raddr = idx(k_r, j_r);
      default: q_rj = j_r;
    endcase
    q_raddr = idx(i_r, q_rj);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_data.kind == KIND_ADVANCE) begin
          state_nxt = warm ? ST_W_RD : ST_U_RD;
        end
      end
      ST_W_RD:   state_nxt = ST_W_EMIT;
      ST_W_EMIT: if (out_free) state_nxt = ij_last ? ST_FIN : ST_W_RD;
      ST_U_RD:   state_nxt = ST_U_SQ;
      ST_U_SQ:   state_nxt = ST_U_SQW;
      ST_U_SQW:  if (sq_done) state_nxt = ST_U_MUL;
      ST_U_MUL:  state_nxt = ST_U_WR;
      ST_U_WR:   state_nxt = i_last ? ST_P_RD : ST_U_RD;
      ST_P_RD:   state_nxt = ST_P_M1;
      ST_P_M1:   state_nxt = ST_P_M2;
      ST_P_M2:   state_nxt = ST_P_M3;
      ST_P_M3:   state_nxt = ST_P_M4;
      ST_P_M4:   state_nxt = ij_last ? ST_R_RD : ST_P_RD;
      ST_R_RD:   state_nxt = ST_R_SQ;
      ST_R_SQ:   state_nxt = ST_R_SQW;
      ST_R_SQW: begin
        if (sq_done) begin
          if (sq_root != 32'd0) state_nxt = ST_R_DV;
          else state_nxt = i_last ? ST_C_RD : ST_R_RD;
        end
      end
      ST_R_DV:   state_nxt = ST_R_DVW;
      ST_R_DVW:  if (dv_done) state_nxt = i_last ? ST_C_RD : ST_R_RD;
      ST_C_RD:   state_nxt = ST_C_M1;
      ST_C_M1:   state_nxt = ST_C_M2;
      ST_C_M2:   state_nxt = ST_C_M3;
      ST_C_M3:   state_nxt = ij_last ? ST_T_RD : ST_C_RD;
      ST_T_RD:   state_nxt = ST_T_MUL;
      ST_T_MUL:  state_nxt = ST_T_ACC;
      ST_T_ACC:  state_nxt = (k_last && ij_last) ? ST_H_RD : ST_T_RD;
      ST_H_RD:   state_nxt = ST_H_MUL;
      ST_H_MUL:  state_nxt = ST_H_ACC;
      ST_H_ACC:  state_nxt = k_last ? ST_H_CRD : ST_H_RD;
      ST_H_CRD:  state_nxt = ST_H_EMIT;
      ST_H_EMIT: if (out_free) state_nxt = ij_last ? ST_FIN : ST_H_RD;
      ST_FIN:    state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath control and counters.
  always_comb begin
    i_nxt    = i_r;
    j_nxt    = j_r;
    k_nxt    = k_r;
    acc_nxt  = acc_r;
    cov_nxt  = cov_r;
    mul_a    = '0;
    mul_b    = '0;
    u_we     = 1'b0;
    rs_we    = 1'b0;
    rs_wdata = dv_quot;
    q_we     = 1'b0;
    q_wdata  = '0;
    c_we     = 1'b0;
    c_wdata  = '0;
    t_we     = 1'b0;
    t_wdata  = '0;
    sq_start = 1'b0;
    dv_start = 1'b0;
    emit     = 1'b0;
    acc_n    = acc_r + prod_sh;
    out_nxt.out_row     = 3'(i_r);
    out_nxt.out_col     = 3'(j_r);
    out_nxt.correlation = $signed(c_rdata);
    out_nxt.covariance  = cov_r;
    out_nxt.last        = ij_last;
    unique case (state_r)
      ST_IDLE: begin
        i_nxt   = '0;
        j_nxt   = '0;
        k_nxt   = '0;
        acc_nxt = '0;
      end
      ST_W_EMIT: begin
        out_nxt.correlation = (i_r == j_r) ? ONE : 32'sd0;
        out_nxt.covariance  = $signed(s_rdata);
        if (out_free) begin
          emit  = 1'b1;
          i_nxt = i_inc;
          j_nxt = j_inc;
        end
      end
      ST_U_SQ: sq_start = 1'b1;
      ST_U_MUL: begin
        mul_a = $signed(sq_root);
        mul_b = prev_r[i_r];
      end
      ST_U_WR: begin
        u_we  = 1'b1;
        i_nxt = i_last ? '0 : i_r + 1'b1;
      end
      ST_P_RD: begin
        mul_a = u_r[i_r];
        mul_b = u_r[j_r];
      end
      ST_P_M1: begin
        mul_a = a_s;
        mul_b = sat32(prod_sh);
      end
      ST_P_M2: begin
        acc_nxt = prod_w;
        mul_a   = c_s;
        mul_b   = $signed(s_rdata);
      end
      ST_P_M3: begin
        acc_nxt = acc_r + prod_w;
        mul_a   = b_s;
        mul_b   = q_rd;
      end
      ST_P_M4: begin
        q_we    = 1'b1;
        q_wdata = sat32(acc_r + prod_w);
        acc_nxt = '0;
        i_nxt   = i_inc;
        j_nxt   = j_inc;
      end
      ST_R_SQ: sq_start = 1'b1;
      ST_R_SQW: begin
        if (sq_done && sq_root == 32'd0) begin
          rs_we    = 1'b1;
          rs_wdata = 32'sh7FFFFFFF;
          i_nxt    = i_last ? '0 : i_r + 1'b1;
        end
      end
      ST_R_DV: dv_start = 1'b1;
      ST_R_DVW: begin
        if (dv_done) begin
          rs_we = 1'b1;
          i_nxt = i_last ? '0 : i_r + 1'b1;
        end
      end
      ST_C_M1: begin
        mul_a = q_rd;
        mul_b = rs_r[i_r];
      end
      ST_C_M2: begin
        mul_a = sat32(prod_sh);
        mul_b = rs_r[j_r];
      end
      ST_C_M3: begin
        c_we    = 1'b1;
        c_wdata = sat32(prod_sh);
        i_nxt   = i_inc;
        j_nxt   = j_inc;
      end
      ST_T_MUL: begin
        mul_a = $signed(d_rdata);
        mul_b = $signed(c_rdata);
      end
      ST_T_ACC: begin
        if (k_last) begin
          t_we    = 1'b1;
          t_wdata = sat32(acc_n);
          acc_nxt = '0;
          k_nxt   = '0;
          i_nxt   = i_inc;
          j_nxt   = j_inc;
        end else begin
          acc_nxt = acc_n;
          k_nxt   = k_r + 1'b1;
        end
      end
      ST_H_MUL: begin
        mul_a = $signed(t_rdata);
        mul_b = $signed(d_rdata);
      end
      ST_H_ACC: begin
        if (k_last) begin
          cov_nxt = sat32(acc_n);
          acc_nxt = '0;
          k_nxt   = '0;
        end else begin
          acc_nxt = acc_n;
          k_nxt   = k_r + 1'b1;
        end
      end
      ST_H_EMIT: begin
        if (out_free) begin
          emit  = 1'b1;
          i_nxt = i_inc;
          j_nxt = j_inc;
        end
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  assign s_we = in_acc && in_data.kind == KIND_TARGET && in_range;
  assign d_we = in_acc && in_data.kind == KIND_SCALE && in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      acc_r       <= '0;
      a_r         <= '0;
      b_r         <= '0;
      warm_r      <= 8'd1;
      step_r      <= '0;
      qv_r        <= '0;
      out_valid_r <= 1'b0;
      for (int n = 0; n < ASSETS; n++) begin
        prev_r[n] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      acc_r   <= acc_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_A_WEIGHT: a_r <= cfg_wdata;
          CFG_B_WEIGHT: b_r <= cfg_wdata;
          CFG_WARMUP:   warm_r <= cfg_wdata[7:0];
          default:      a_r <= a_r;
        endcase
      end
      if (q_we) begin
        qv_r[idx(i_r, j_r)] <= 1'b1;
      end
      if (state_r == ST_FIN) begin
        for (int n = 0; n < ASSETS; n++) begin
          prev_r[n] <= cur_r[n];
        end
        if (step_r != 8'hFF) step_r <= step_r + 8'd1;
      end
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
    prod_r    <= mul_a * mul_b;
    cov_r     <= cov_nxt;
    q_rv_r    <= qv_r[q_raddr];
    q_rdiag_r <= (q_rj == i_r);
    if (emit) out_data_r <= out_nxt;
    if (in_acc && in_data.kind == KIND_RESID && {1'b0, in_data.row} < 4'(ASSETS)) begin
      cur_r[in_data.row[IW-1:0]] <= in_data.value;
    end
    if (u_we) u_r[i_r] <= sat32(prod_sh);
    if (rs_we) rs_r[i_r] <= rs_wdata;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  dcc_ram #(.WIDTH(32), .DEPTH(NN)) u_s_ram (
    .clk(clk), .we(s_we), .waddr(ld_addr), .wdata(in_data.value),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  dcc_ram #(.WIDTH(32), .DEPTH(NN)) u_d_ram (
    .clk(clk), .we(d_we), .waddr(ld_addr), .wdata(in_data.value),
    .raddr(d_raddr), .rdata(d_rdata)
  );

  dcc_ram #(.WIDTH(32), .DEPTH(NN)) u_q_ram (
    .clk(clk), .we(q_we), .waddr(idx(i_r, j_r)), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  dcc_ram #(.WIDTH(32), .DEPTH(NN)) u_c_ram (
    .clk(clk), .we(c_we), .waddr(idx(i_r, j_r)), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  dcc_ram #(.WIDTH(32), .DEPTH(NN)) u_t_ram (
    .clk(clk), .we(t_we), .waddr(idx(i_r, j_r)), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  dcc_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .x(sq_x),
    .busy(sq_busy), .done(sq_done), .root(sq_root)
  );

  dcc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .divisor(sq_root),
    .busy(dv_busy), .done(dv_done), .quot_sat(dv_quot)
  );

  a_units_quiet_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!sq_busy && !dv_busy))
    else $error("iterative unit busy while sequencer idle");

  a_advance_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.kind == KIND_ADVANCE) |=> (state_r != ST_IDLE))
    else $error("advance request did not start a step");

  a_step_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && step_r != 8'hFF) |=> (step_r == $past(step_r) + 8'd1))
    else $error("step counter did not advance");

endmodule

### dv/testbench.sv
// Self-checking testbench for the DCC correlation filter core with a built-in step predictor.
module testbench;
  import dcc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N = 4;
  localparam int NN = N * N;
  localparam int STALL_LIMIT = 40000;
  localparam longint ONE = 64'sd65536;
  localparam longint MAXV = 64'sd2147483647;
  localparam longint MINV = -64'sd2147483648;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_req_t in_data;
  out_rsp_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_wdata;

  dcc_correlation_filter_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  in_req_t pending_reqs[$];
  out_rsp_t expected_elems[$];
  logic in_taken;
  int send_idle, recv_idle;
  int mismatches, errors, stall_cycles, steps_seen, elems_seen;

  longint tgt[NN], rq[NN], scl[NN], e_cur[N], e_prev[N];
  int step_cnt;
  int unsigned aw, bw, wu;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint sat(longint x);
    if (x > MAXV) return MAXV;
    if (x < MINV) return MINV;
    return x;
  endfunction

  function automatic longint fmul(longint x, longint y);
    return (x * y) >>> 16;
  endfunction

  function automatic longint usqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint fsqrt(longint v);
    if (v <= 0) return 0;
    return usqrt(longint'(v) << 16);
  endfunction

  task automatic filter_step(in_req_t r);
    longint corr[NN], cov[NN], tmp[NN], qn[NN], u[N], rs[N];
    longint c, p, s, d;
    out_rsp_t o;
    int idx;
    idx = int'(r.row) * N + int'(r.col);
    case (r.kind)
      KIND_TARGET: if (r.row < N && r.col < N) tgt[idx] = longint'(r.value);
      KIND_SCALE: if (r.row < N && r.col < N) scl[idx] = longint'(r.value);
      KIND_RESID: if (r.row < N) e_cur[r.row] = longint'(r.value);
      default: begin
        if (step_cnt < wu) begin
          for (int i = 0; i < NN; i++) begin
            corr[i] = (i / N == i % N) ? ONE : 0;
            cov[i] = tgt[i];
          end
        end else begin
          c = 65536 - longint'(aw) - longint'(bw);
          for (int i = 0; i < N; i++) u[i] = sat(fmul(fsqrt(rq[i * N + i]), e_prev[i]));
          for (int i = 0; i < N; i++)
            for (int j = 0; j < N; j++) begin
              p = sat(fmul(u[i], u[j]));
              s = ((c * tgt[i * N + j]) >>> 16) + ((longint'(aw) * p) >>> 16)
                + ((longint'(bw) * rq[i * N + j]) >>> 16);
              qn[i * N + j] = sat(s);
            end
          rq = qn;
          for (int i = 0; i < N; i++) begin
            d = fsqrt(qn[i * N + i]);
            rs[i] = (d <= 0) ? MAXV : sat((64'sd1 << 32) / d);
          end
          for (int i = 0; i < N; i++)
            for (int j = 0; j < N; j++)
              corr[i * N + j] = sat(fmul(sat(fmul(qn[i * N + j], rs[i])), rs[j]));
          for (int i = 0; i < N; i++)
            for (int j = 0; j < N; j++) begin
              s = 0;
              for (int k = 0; k < N; k++) s += fmul(scl[i * N + k], corr[k * N + j]);
              tmp[i * N + j] = sat(s);
            end
          for (int i = 0; i < N; i++)
            for (int j = 0; j < N; j++) begin
              s = 0;
              for (int k = 0; k < N; k++) s += fmul(tmp[i * N + k], scl[k * N + j]);
              cov[i * N + j] = sat(s);
            end
        end
        e_prev = e_cur;
        if (step_cnt < 255) step_cnt++;
        steps_seen++;
        for (int i = 0; i < NN; i++) begin
          o.out_row = 3'(i / N);
          o.out_col = 3'(i % N);
          o.correlation = corr[i][31:0];
          o.covariance = cov[i][31:0];
          o.last = (i == NN - 1);
          expected_elems.push_back(o);
        end
      end
    endcase
  endtask

  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        in_data <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk) begin
    in_taken <= in_valid && in_ready && rst_n;
    if (rst_n) begin
      if (in_valid && in_ready) filter_step(in_data);
      if (out_valid && out_ready) begin
        elems_seen++;
        if (expected_elems.size() == 0) begin
          errors++;
          if (mismatches < 10) $display("unexpected result %p", out_data);
          mismatches++;
        end else if (out_data !== expected_elems[0]) begin
          errors++;
          if (mismatches < 10)
            $display("mismatch: expected %p actual %p", expected_elems[0], out_data);
          mismatches++;
          void'(expected_elems.pop_front());
        end else begin
          void'(expected_elems.pop_front());
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (stall_cycles > STALL_LIMIT) begin
      $display("watchdog: no request or result moved for %0d cycles", stall_cycles);
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic add_req(kind_t k, int r, int c, logic [31:0] v);
    in_req_t q;
    q.kind = k;
    q.row = 3'(r);
    q.col = 3'(c);
    q.value = v;
    pending_reqs.push_back(q);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($urandom_range(0, 32'h0003_0000));
      2: return 32'($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
      3: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($urandom_range(0, 32'h0000_4000));
    endcase
  endfunction

  task automatic add_random(int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 12) add_req(KIND_ADVANCE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
      else if (sel < 22)
        add_req(kind_t'($urandom_range(0, 2)), $urandom_range(4, 7), $urandom_range(0, 7),
                $urandom);
      else add_req(kind_t'($urandom_range(0, 2)), $urandom_range(0, 3), $urandom_range(0, 3),
                   rand_value());
    end
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_A_WEIGHT: aw = data;
      CFG_B_WEIGHT: bw = data;
      CFG_WARMUP: wu = data[7:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_elems.size() != 0);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_A_WEIGHT;
    cfg_wdata = '0;
    in_taken = 1'b0;
    mismatches = 0;
    errors = 0;
    stall_cycles = 0;
    steps_seen = 0;
    elems_seen = 0;
    for (int i = 0; i < NN; i++) begin
      tgt[i] = 0;
      scl[i] = 0;
      rq[i] = (i / N == i % N) ? ONE : 0;
    end
    for (int i = 0; i < N; i++) begin
      e_cur[i] = 0;
      e_prev[i] = 0;
    end
    step_cnt = 0;
    aw = 0;
    bw = 0;
    wu = 1;
    send_idle = 6;
    recv_idle = 84;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NN; i++) begin
      add_req(KIND_TARGET, i / N, i % N, (i / N == i % N) ? 32'h0001_8000 : rand_value());
      add_req(KIND_SCALE, i / N, i % N, (i / N == i % N) ? 32'h0001_0000 : rand_value());
    end
    for (int i = 0; i < N; i++) add_req(KIND_RESID, i, 0, rand_value());
    add_req(KIND_TARGET, 0, 1, 32'h7FFF_FFFF);
    add_req(KIND_TARGET, 1, 0, 32'h8000_0000);
    add_req(KIND_TARGET, 7, 7, 32'hFFFF_FFFF);
    add_req(KIND_SCALE, 2, 5, 32'h1234_5678);
    add_req(KIND_RESID, 6, 7, 32'h0000_0000);
    add_req(KIND_ADVANCE, 0, 0, 32'h0);
    add_req(KIND_ADVANCE, 7, 7, 32'hFFFF_FFFF);
    add_random(30);
    drain();

    for (int ph = 1; ph < 6; ph++) begin
      if (ph == 2) begin
        send_idle = 84;
        recv_idle = 6;
      end else if (ph == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      case (ph)
        1: begin
          cfg_write(CFG_A_WEIGHT, 16'h0000);
          cfg_write(CFG_B_WEIGHT, 16'h0000);
          cfg_write(CFG_WARMUP, 16'h0000);
        end
        2: begin
          cfg_write(CFG_A_WEIGHT, 16'hFFFF);
          cfg_write(CFG_B_WEIGHT, 16'hFFFF);
          cfg_write(CFG_WARMUP, 16'h00FF);
          cfg_write(2'd3, 16'hFFFF);
        end
        3: begin
          cfg_write(CFG_A_WEIGHT, 16'h0CCC);
          cfg_write(CFG_B_WEIGHT, 16'hE666);
          cfg_write(CFG_WARMUP, 16'h0001);
        end
        4: begin
          cfg_write(CFG_A_WEIGHT, 16'($urandom_range(0, 16'h2000)));
          cfg_write(CFG_B_WEIGHT, 16'($urandom_range(16'h8000, 16'hD000)));
          cfg_write(CFG_WARMUP, 16'h00FF);
        end
        default: begin
          cfg_write(CFG_A_WEIGHT, 16'($urandom));
          cfg_write(CFG_B_WEIGHT, 16'($urandom));
          cfg_write(CFG_WARMUP, 16'($urandom_range(1, 255)));
        end
      endcase
      @(negedge clk);
      cfg_we <= 1'b0;
      if (ph == 1) begin
        add_req(KIND_TARGET, 0, 0, 32'hFFFF_0000);
        add_req(KIND_TARGET, 3, 3, 32'h0000_0000);
        add_req(KIND_ADVANCE, 0, 0, 32'h0);
      end
      add_random(30);
      drain();
    end

    errors += expected_elems.size();
    $display("covered %0d advance steps and %0d result elements over six register settings",
             steps_seen, elems_seen);
    $display("%0d mismatches counted", mismatches);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

### dcc_correlation_filter_core.f
hw/rtl/dcc_pkg.sv
hw/rtl/dcc_ram.sv
hw/rtl/dcc_sqrt.sv
hw/rtl/dcc_div.sv
hw/rtl/dcc_correlation_filter_core.sv
dv/testbench.sv
